/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Define NO_ASSERTIONS to
// compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/lvt_pkg.sv */
// ----------------------------------------------------------------------------
// lvt_pkg
// Types and constants of the label vote table.
// ----------------------------------------------------------------------------
package lvt_pkg;

  localparam int NumSlotsDef  = 8;
  localparam int LabelBitsDef = 16;
  localparam int FieldW       = 16;  // label and winner fields on the ports
  localparam int ConfW        = 16;  // stored confidence
  localparam int ObsConfW     = 8;   // confidence of one observation

  typedef enum logic {
    CmdAdd    = 1'b0,
    CmdDecide = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWb
  } state_e;

  typedef struct packed {
    cmd_e                command;
    logic [FieldW-1:0]   obs_label;
    logic [ObsConfW-1:0] obs_confidence;
    logic [FieldW-1:0]   tie_label;
  } in_item_t;

  typedef struct packed {
    logic [FieldW-1:0] winner_label;
    logic [ConfW-1:0]  winner_confidence;
    logic              dropped;
  } out_item_t;

endpackage

/* rtl/lvt_ram.sv */
// ----------------------------------------------------------------------------
// lvt_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lvt_ram #(
  parameter int Width = 32,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/label_vote_table.sv */
// ----------------------------------------------------------------------------
// label_vote_table
// Label vote table of one voxel: per-label confidence slots, add and decide.
// ----------------------------------------------------------------------------
// Flow: a new item is taken only while idle, after the last one is written back;
//   the slot RAM is read one entry per cycle through its single read port
//   and one shared compare stage, followed by a write-back state that waits
//   while the output is stalled and then registers the result.
// Reset: asynchronous, active low; all slots read as empty at once through
//   per-slot valid bits, and the stored winner clears to label 0, confidence 0.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module label_vote_table #(
  parameter int NUM_SLOTS  = lvt_pkg::NumSlotsDef,
  parameter int LABEL_BITS = lvt_pkg::LabelBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lvt_pkg::in_item_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lvt_pkg::out_item_t out_data_o
);

  // Labels keep their low LABEL_BITS bits, capped at the port field width.
  localparam int LblW  = (LABEL_BITS < lvt_pkg::FieldW) ? LABEL_BITS : lvt_pkg::FieldW;
  localparam int ConfW = lvt_pkg::ConfW;
  localparam int IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RamW  = LblW + ConfW;

  // --------------------------------------------------------------------------
  // Sequencer state
  // --------------------------------------------------------------------------
  lvt_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            accept;
  logic            out_free;
  logic            finish;
  logic            ram_re;

  // Latched item (payload, no reset needed)
  lvt_pkg::cmd_e                cmd_q;
  logic [LblW-1:0]              lbl_q;
  logic [lvt_pkg::ObsConfW-1:0] oconf_q;
  logic [LblW-1:0]              pref_q;

  // Compare stage: one slot per cycle behind the RAM read
  logic            cmp_vld_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic [RamW-1:0] ram_rdata;
  logic [LblW-1:0] rd_lbl;
  logic [ConfW-1:0] rd_conf;

  // Scan trackers
  logic             hit_q, hit_d;
  logic [IdxW-1:0]  hit_idx_q, hit_idx_d;
  logic [ConfW-1:0] hit_conf_q, hit_conf_d;
  logic             emp_q, emp_d;
  logic [IdxW-1:0]  emp_idx_q, emp_idx_d;
  logic [LblW-1:0]  win_lbl_q, win_lbl_d;
  logic [ConfW-1:0] win_conf_q, win_conf_d;

  // Stored winner and slot valid bits
  logic [LblW-1:0]      best_lbl_q, best_lbl_d;
  logic [ConfW-1:0]     best_conf_q, best_conf_d;
  logic [NUM_SLOTS-1:0] slot_vld_q;

  // Write-back
  logic             ram_we;
  logic [IdxW-1:0]  ram_waddr;
  logic [RamW-1:0]  ram_wdata;
  logic [ConfW:0]   sum;
  logic [ConfW-1:0] sat_conf;
  logic             is_add_live;
  logic             drop;

  // Output register
  logic               out_valid_q;
  lvt_pkg::out_item_t out_q, out_d;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign finish   = (state_q == lvt_pkg::StWb) && out_free;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      lvt_pkg::StIdle: begin
        if (accept) begin
          state_d  = lvt_pkg::StScan;
          rd_idx_d = '0;
        end
      end
      lvt_pkg::StScan: begin
        // Issue one slot read per cycle; the last one goes to write-back.
        if (rd_idx_q == IdxW'(NUM_SLOTS - 1)) begin
          state_d = lvt_pkg::StWb;
        end else begin
          rd_idx_d = rd_idx_q + IdxW'(1);
        end
      end
      lvt_pkg::StWb: begin
        // Hold until the output register can take the result.
        if (out_free) begin
          state_d = lvt_pkg::StIdle;
        end
      end
      default: begin
        state_d = lvt_pkg::StIdle;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    case (state_q)
      lvt_pkg::StIdle: in_stall_o = 1'b0;
      lvt_pkg::StScan: ram_re     = 1'b1;
      lvt_pkg::StWb:   ram_re     = 1'b0;
      default:         in_stall_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lvt_pkg::StIdle;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= ram_re;
      cmp_idx_q <= rd_idx_q;
    end
  end

  // Capture the item on its transaction; labels trimmed to the stored width.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= in_data_i.command;
      lbl_q   <= in_data_i.obs_label[LblW-1:0];
      oconf_q <= in_data_i.obs_confidence;
      pref_q  <= in_data_i.tie_label[LblW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Slot RAM: {label, confidence}; a slot never written reads as empty.
  // --------------------------------------------------------------------------
  lvt_ram #(
    .Width (RamW),
    .Depth (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (slot_vld_q[cmp_idx_q]) begin
      rd_lbl  = ram_rdata[RamW-1:ConfW];
      rd_conf = ram_rdata[ConfW-1:0];
    end else begin
      rd_lbl  = '0;
      rd_conf = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Shared compare stage. Add: find the matching slot and the first empty
  // one. Decide: keep a strictly greater confidence, or an equal one that
  // carries the nonzero tie label.
  // --------------------------------------------------------------------------
  always_comb begin
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_conf_d = hit_conf_q;
    emp_d      = emp_q;
    emp_idx_d  = emp_idx_q;
    win_lbl_d  = win_lbl_q;
    win_conf_d = win_conf_q;
    if (accept) begin
      hit_d      = 1'b0;
      hit_idx_d  = '0;
      hit_conf_d = '0;
      emp_d      = 1'b0;
      emp_idx_d  = '0;
      win_lbl_d  = '0;
      win_conf_d = '0;
    end else if (cmp_vld_q) begin
      if (cmd_q == lvt_pkg::CmdAdd) begin
        if (!hit_q && (rd_lbl == lbl_q)) begin
          hit_d      = 1'b1;
          hit_idx_d  = cmp_idx_q;
          hit_conf_d = rd_conf;
        end
        if (!emp_q && (rd_lbl == '0)) begin
          emp_d     = 1'b1;
          emp_idx_d = cmp_idx_q;
        end
      end else begin
        if ((rd_conf > win_conf_q) ||
            ((pref_q != '0) && (rd_lbl == pref_q) && (rd_conf == win_conf_q))) begin
          win_lbl_d  = rd_lbl;
          win_conf_d = rd_conf;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      hit_conf_q <= '0;
      emp_q      <= 1'b0;
      emp_idx_q  <= '0;
      win_lbl_q  <= '0;
      win_conf_q <= '0;
    end else begin
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      hit_conf_q <= hit_conf_d;
      emp_q      <= emp_d;
      emp_idx_q  <= emp_idx_d;
      win_lbl_q  <= win_lbl_d;
      win_conf_q <= win_conf_d;
    end
  end

  // --------------------------------------------------------------------------
  // Write-back. The tracker values already include the last slot compared.
  // A zero label changes nothing; a full table drops a label that it does not hold.
  // --------------------------------------------------------------------------
  assign sum         = {1'b0, hit_conf_d} + (ConfW + 1)'(oconf_q);
  assign sat_conf    = sum[ConfW] ? '1 : sum[ConfW-1:0];
  assign is_add_live = (cmd_q == lvt_pkg::CmdAdd) && (lbl_q != '0);
  assign drop        = is_add_live && !hit_d && !emp_d;

  assign ram_we    = finish && is_add_live && (hit_d || emp_d);
  assign ram_waddr = hit_d ? hit_idx_d : emp_idx_d;
  assign ram_wdata = {lbl_q, (hit_d ? sat_conf : ConfW'(oconf_q))};

  always_comb begin
    best_lbl_d  = best_lbl_q;
    best_conf_d = best_conf_q;
    if (cmd_q == lvt_pkg::CmdDecide) begin
      best_lbl_d  = win_lbl_d;
      best_conf_d = win_conf_d;
    end
  end

  always_comb begin
    out_d                   = out_q;
    out_d.winner_label      = lvt_pkg::FieldW'(best_lbl_d);
    out_d.winner_confidence = best_conf_d;
    out_d.dropped           = drop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_lbl_q  <= '0;
      best_conf_q <= '0;
      slot_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        best_lbl_q  <= best_lbl_d;
        best_conf_q <= best_conf_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        // Drop the result once its transaction completes.
        out_valid_q <= 1'b0;
      end
      if (ram_we) begin
        slot_vld_q[ram_waddr] <= 1'b1;
      end
    end
  end

  // Result payload: load only on write-back, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A new item always starts its scan at slot zero.
  `ASSERT_NEXT(a_scan_start, clk_i, rst_ni, accept, state_q == lvt_pkg::StScan && rd_idx_q == '0)
  // Every slot read issued is compared in the following cycle.
  `ASSERT_NEXT(a_cmp_follows, clk_i, rst_ni, ram_re, cmp_vld_q)
  // A table write ends the item and hands a result to the output.
  `ASSERT_NEXT(a_write_ends, clk_i, rst_ni, ram_we, (state_q == lvt_pkg::StIdle) && out_valid_q)
  // A drop reported on the output came from an add.
  `ASSERT_IMPLIES(a_drop_add, clk_i, rst_ni, finish && drop, cmd_q == lvt_pkg::CmdAdd)

endmodule

/* tb/tb_label_vote_table.sv */
// ----------------------------------------------------------------------------
// tb_label_vote_table
// Self-checking bench for the voxel label vote table. A directed table walks
// the empty-table, tie, table-full and label-zero corners. A long random run
// then hammers the filled table with skewed labels until slots saturate.
// Results are checked against typed values or the in-bench slot-table model.
// ----------------------------------------------------------------------------
module tb_label_vote_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NumSlots    = lvt_pkg::NumSlotsDef;
  localparam int          LabelBits   = lvt_pkg::LabelBitsDef;
  localparam time         ClkPeriod   = 10ns;
  localparam int          RandItems   = 1400;
  localparam int          PoolSize    = 12;
  localparam logic [15:0] LabelMask   =
      (LabelBits >= 16) ? 16'hFFFF : 16'((32'd1 << LabelBits) - 1);

  // Directed stimulus row: the transaction, and a hand-written expected
  // result where one is obvious (otherwise the model supplies it).
  typedef struct packed {
    lvt_pkg::in_item_t  stim;
    logic               typed;
    lvt_pkg::out_item_t want;
  } dir_row_t;

  localparam int NumDir = 20;
  localparam dir_row_t DirRows [NumDir] = '{
    // empty table: decide reports nothing observed
    '{'{lvt_pkg::CmdDecide, 16'h1357, 8'h3C, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    // label zero observation is ignored
    '{'{lvt_pkg::CmdAdd,    16'h0000, 8'hFF, 16'hFFFF}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    // zero-confidence slot; add never re-decides
    '{'{lvt_pkg::CmdAdd,    16'hFFFF, 8'h00, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    '{'{lvt_pkg::CmdDecide, 16'h0000, 8'h00, 16'h0000}, 1'b1, '{16'h0000, 16'h0000, 1'b0}},
    // tie label takes the tie at confidence zero
    '{'{lvt_pkg::CmdDecide, 16'h0000, 8'h00, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
    '{'{lvt_pkg::CmdAdd,    16'h0001, 8'hFF, 16'h0000}, 1'b1, '{16'hFFFF, 16'h0000, 1'b0}},
    '{'{lvt_pkg::CmdDecide, 16'h0000, 8'h00, 16'h0000}, 1'b1, '{16'h0001, 16'h00FF, 1'b0}},
    '{'{lvt_pkg::CmdAdd,    16'hFFFF, 8'hFF, 16'h0000}, 1'b1, '{16'h0001, 16'h00FF, 1'b0}},
    // equal confidence, no preference: first slot in scan order stays
    '{'{lvt_pkg::CmdDecide, 16'h0000, 8'h00, 16'h0000}, 1'b1, '{16'hFFFF, 16'h00FF, 1'b0}},
    // equal confidence, tie label in a later slot wins
    '{'{lvt_pkg::CmdDecide, 16'hFFFF, 8'hFF, 16'h0001}, 1'b1, '{16'h0001, 16'h00FF, 1'b0}},
    // fill the remaining slots
    '{'{lvt_pkg::CmdAdd,    16'h8000, 8'h80, 16'h0000}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'h5555, 8'h55, 16'hAAAA}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'hAAAA, 8'hAA, 16'h5555}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'h0F0F, 8'h01, 16'h0000}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'hF0F0, 8'hFE, 16'h0000}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'h0001, 8'hFF, 16'h0000}, 1'b0, '0},
    '{'{lvt_pkg::CmdAdd,    16'h1234, 8'h7F, 16'h0000}, 1'b0, '0},
    // table full: new label is dropped and flagged
    '{'{lvt_pkg::CmdAdd,    16'h4321, 8'h10, 16'h0000}, 1'b1, '{16'h0001, 16'h00FF, 1'b1}},
    // label zero on a full table is still ignored, not dropped
    '{'{lvt_pkg::CmdAdd,    16'h0000, 8'h10, 16'h0000}, 1'b1, '{16'h0001, 16'h00FF, 1'b0}},
    '{'{lvt_pkg::CmdDecide, 16'h0000, 8'h00, 16'h0000}, 1'b0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  lvt_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  lvt_pkg::out_item_t out_data_o;

  // Model of the slot table and the stored winner.
  logic [15:0] slot_lbl  [NumSlots];
  logic [15:0] slot_conf [NumSlots];
  logic [15:0] best_lbl;
  logic [15:0] best_conf;

  lvt_pkg::out_item_t pending_winners [$];   // expected results, oldest first
  int unsigned mismatch_cnt = 0;
  int unsigned result_idx   = 0;
  int unsigned burst_left   = 0;

  label_vote_table #(
    .NUM_SLOTS  (NumSlots),
    .LABEL_BITS (LabelBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Apply one transaction to the model table and return the result it causes.
  function automatic lvt_pkg::out_item_t vote_apply(input lvt_pkg::in_item_t it);
    logic [15:0]        lbl;
    logic [15:0]        pref;
    logic [15:0]        win_lbl;
    logic [15:0]        win_conf;
    logic [16:0]        sum;
    logic               hit;
    logic               dropped;
    lvt_pkg::out_item_t res;
    lbl     = it.obs_label & LabelMask;
    pref    = it.tie_label & LabelMask;
    dropped = 1'b0;
    if (it.command == lvt_pkg::CmdAdd) begin
      if (lbl != '0) begin
        hit = 1'b0;
        // Accumulate into the matching slot, saturating at full scale.
        for (int k = 0; k < NumSlots; k++) begin
          if (!hit && slot_lbl[k] == lbl) begin
            sum          = {1'b0, slot_conf[k]} + 17'(it.obs_confidence);
            slot_conf[k] = sum[16] ? 16'hFFFF : sum[15:0];
            hit          = 1'b1;
          end
        end
        // No match: claim the first empty slot.
        for (int k = 0; k < NumSlots; k++) begin
          if (!hit && slot_lbl[k] == '0) begin
            slot_lbl[k]  = lbl;
            slot_conf[k] = 16'(it.obs_confidence);
            hit          = 1'b1;
          end
        end
        dropped = !hit;
      end
    end else begin
      win_lbl  = '0;
      win_conf = '0;
      for (int k = 0; k < NumSlots; k++) begin
        if (slot_conf[k] > win_conf ||
            (pref != '0 && slot_lbl[k] == pref && slot_conf[k] == win_conf)) begin
          win_lbl  = slot_lbl[k];
          win_conf = slot_conf[k];
        end
      end
      best_lbl  = win_lbl;
      best_conf = win_conf;
    end
    res.winner_label      = best_lbl;
    res.winner_confidence = best_conf;
    res.dropped           = dropped;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, result_idx, what, got, want);
    mismatch_cnt++;
  endtask

  // Present one transaction and hold it until accepted, then queue the
  // expected result: the typed one if given, else the model's.
  task automatic offer_item(input lvt_pkg::in_item_t it, input logic typed,
                            input lvt_pkg::out_item_t want);
    lvt_pkg::out_item_t pred;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pred = vote_apply(it);
    pending_winners.push_back(typed ? want : pred);
  endtask

  // Sender pacing: run bursts back to back, then drop valid for a random gap.
  // An occasional long burst keeps the input busy with no idling at all.
  task automatic sender_pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(0, 15);
      gap        = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: open windows of random length separated by short stalls, with
  // the odd long open stretch.
  initial begin : receiver_stall
    int unsigned open_len;
    int unsigned hold_len;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      open_len = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 30);
      out_stall_i <= 1'b0;
      repeat (open_len) @(posedge clk_i);
      hold_len = $urandom_range(0, 12);
      if (hold_len != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
      end
    end
  end

  // Check every accepted result against the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    lvt_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_winners.size() == 0) begin
        report_mismatch("unexpected result, label", out_data_o.winner_label, 0);
      end else begin
        want = pending_winners.pop_front();
        if (out_data_o.winner_label !== want.winner_label) begin
          report_mismatch("winner_label", out_data_o.winner_label, want.winner_label);
        end
        if (out_data_o.winner_confidence !== want.winner_confidence) begin
          report_mismatch("winner_confidence", out_data_o.winner_confidence,
                          want.winner_confidence);
        end
        if (out_data_o.dropped !== want.dropped) begin
          report_mismatch("dropped", out_data_o.dropped, want.dropped);
        end
      end
      result_idx++;
    end
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin : watchdog
    #(4ms);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [15:0]       label_pool [PoolSize];
    lvt_pkg::in_item_t it;
    int unsigned       pick;

    // Drive every input to a known value and hold reset.
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    for (int k = 0; k < NumSlots; k++) begin
      slot_lbl[k]  = '0;
      slot_conf[k] = '0;
    end
    best_lbl  = '0;
    best_conf = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners.
    for (int r = 0; r < NumDir; r++) begin
      offer_item(DirRows[r].stim, DirRows[r].typed, DirRows[r].want);
      sender_pace();
    end

    // Random part. The table is full now, so build the label pool from its
    // contents plus a few outsiders that will be dropped. Slots 0 and 1 get
    // most of the traffic so they saturate and tie at full scale.
    for (int k = 0; k < PoolSize; k++) begin
      label_pool[k] = (k < NumSlots) ? slot_lbl[k] : 16'($urandom_range(1, 65535));
    end
    for (int n = 0; n < RandItems; n++) begin
      it.command         = ($urandom_range(0, 3) == 0) ? lvt_pkg::CmdDecide : lvt_pkg::CmdAdd;
      it.obs_confidence  = ($urandom_range(0, 9) < 6) ? 8'hFF : 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 35)      it.obs_label = label_pool[0];
      else if (pick < 70) it.obs_label = label_pool[1];
      else if (pick < 85) it.obs_label = label_pool[$urandom_range(2, NumSlots - 1)];
      else if (pick < 92) it.obs_label = label_pool[$urandom_range(NumSlots, PoolSize - 1)];
      else if (pick < 96) it.obs_label = 16'($urandom);
      else                it.obs_label = '0;
      pick = $urandom_range(0, 3);
      if (pick < 2)       it.tie_label = label_pool[$urandom_range(0, NumSlots - 1)];
      else if (pick == 2) it.tie_label = '0;
      else                it.tie_label = 16'($urandom);
      offer_item(it, 1'b0, '0);
      sender_pace();
    end

    // Drain: wait for every expected result, then allow for stragglers.
    in_valid_i <= 1'b0;
    while (pending_winners.size() != 0) @(posedge clk_i);
    repeat (NumSlots + 4) @(posedge clk_i);

    if (mismatch_cnt == 0 && pending_winners.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
